### src/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// shared types and constants of the perceptron training step
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int unsigned SQRT_STEPS  = 32;
    localparam logic [15:0] RATE_RESET  = 16'd4096;
    localparam logic signed [64:0] SCORE_MAX = 65'sd140737488355327;
    localparam logic signed [64:0] SCORE_MIN = -65'sd140737488355328;
    localparam logic signed [33:0] W_MAX = 34'sd2147483647;
    localparam logic signed [33:0] W_MIN = -34'sd2147483648;

    typedef logic signed [31:0] t_weight;
    typedef logic signed [15:0] t_feature;

endpackage

### src/pts_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_store
// weight and sample feature memories, one write port each, a shared read port
// ----------------------------------------------------------------------------
module pts_store import pts_pkg::*; #(
    parameter int DIM_MAX = 64,
    parameter int AW      = 6
) (
    input  logic          i_clk,
    input  logic          i_w_we,
    input  logic [AW-1:0] i_w_waddr,
    input  t_weight       i_w_wdata,
    input  logic          i_s_we,
    input  logic [AW-1:0] i_s_waddr,
    input  t_feature      i_s_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_weight       o_w_rdata,
    output t_feature      o_s_rdata
);

    t_weight  r_wmem [DIM_MAX];
    t_feature r_smem [DIM_MAX];

    always_ff @(posedge i_clk) begin
        if (i_w_we) begin
            r_wmem[i_w_waddr] <= i_w_wdata;
        end
        if (i_s_we) begin
            r_smem[i_s_waddr] <= i_s_wdata;
        end
        if (i_re) begin
            o_w_rdata <= r_wmem[i_raddr];
            o_s_rdata <= r_smem[i_raddr];
        end
    end

endmodule

### src/pts_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_isqrt
// integer square root of a 64 bit value, one result bit per cycle
// ----------------------------------------------------------------------------
module pts_isqrt import pts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [63:0] r_n;
    logic [33:0] r_rem;
    logic [4:0]  r_step;
    logic        r_busy;
    logic [33:0] w_rem;
    logic [33:0] w_trial;

    assign w_rem   = {r_rem[31:0], r_n[63:62]};
    assign w_trial = {o_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_step <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_n    <= i_radicand;
                r_rem  <= '0;
                o_root <= '0;
            end else if (r_busy) begin
                r_n <= {r_n[61:0], 2'b00};
                if (w_rem >= w_trial) begin
                    r_rem  <= w_rem - w_trial;
                    o_root <= {o_root[30:0], 1'b1};
                end else begin
                    r_rem  <= w_rem;
                    o_root <= {o_root[30:0], 1'b0};
                end
                r_step <= r_step + 5'd1;
                if (r_step == 5'(SQRT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

### src/perceptron_train_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perceptron_train_step
// online perceptron training in fixed point, weights held in memory
// ----------------------------------------------------------------------------
// usage
//   input channel: one feature request per item (i_valid / o_stall); the item
//   with i_last_feature ends the sample and carries the label
//   output channel: one result per sample (o_valid / i_stall), from an
//   output register, so the next sample's features are taken while it waits
//   learning rate: i_cfg_wr_en / i_cfg_wr_data, only while the block is idle
//   per feature: memory read, then registered multiply (o_stall high); the
//   accumulate overlaps the next request
//   last feature, correct class: multiply, accumulate, score, done state
//   mistake: per sample feature a read, step and write back, then per
//   stored weight a read, square and add for the norm, then the square root
//   reset: a clearing pass over all DIM_MAX entries zeroes the weight memory,
//   o_stall is high meanwhile
//   a stalled result holds; a finished sample waits for the output register
// ----------------------------------------------------------------------------
module perceptron_train_step import pts_pkg::*; #(
    parameter int DIM_MAX = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic signed [15:0] i_feature,
    input  logic        i_label_positive,
    input  logic        i_last_feature,
    input  logic        i_new_pass,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_mistake,
    output logic signed [47:0] o_score,
    output logic [31:0] o_weight_norm,
    output logic [15:0] o_pass_mistakes,
    output logic [31:0] o_total_updates,
    output logic        o_too_many_features
);

    localparam int AW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
    localparam int CW = $clog2(DIM_MAX + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MUL, S_ACC, S_SCORE, S_UPD_RD, S_UPD_MUL, S_UPD_WR,
        S_NRM_RD, S_NRM_SQ, S_NRM_ADD, S_SQRT, S_DONE
    } t_state;

    t_state r_state;
    logic [15:0] r_rate;
    logic [CW-1:0] r_cnt, r_idx;
    logic r_ovf, r_have, r_last, r_pos, r_pend, r_miss;
    t_feature r_x;
    logic signed [47:0] r_prod, r_score;
    logic signed [63:0] r_acc;
    logic signed [25:0] r_step;
    logic [63:0] r_sq, r_sum;
    t_weight r_bias;
    logic [31:0] r_norm, r_upd;
    logic [15:0] r_mcnt;

    logic w_accept, w_fits, w_re, w_we, w_sqrt_start, w_sqrt_done;
    logic [AW-1:0] w_raddr;
    t_weight w_wdata, w_rd_w;
    t_feature w_rd_s;
    logic [31:0] w_root;

    // datapath helpers
    logic signed [63:0] w_sh;
    logic signed [64:0] w_sc_raw;
    logic signed [47:0] w_sc;
    logic signed [32:0] w_rx;
    logic signed [33:0] w_d;
    logic signed [33:0] w_wsum, w_bsum;
    logic [31:0] w_mag;
    logic [64:0] w_acc_sum;
    logic signed [20:0] w_bstep;
    logic w_out_free;
    logic [31:0] n_upd;
    logic [15:0] n_mcnt;

    assign w_fits   = (r_cnt < CW'(DIM_MAX));
    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_out_free = !o_valid || !i_stall;

    // score: floor(acc / 2^12) + bias, saturated to 48 bits
    assign w_sh     = r_acc >>> 12;
    assign w_sc_raw = 65'(w_sh) + 65'(r_bias);
    always_comb begin
        if (w_sc_raw > SCORE_MAX) begin
            w_sc = 48'(SCORE_MAX);
        end else if (w_sc_raw < SCORE_MIN) begin
            w_sc = 48'(SCORE_MIN);
        end else begin
            w_sc = w_sc_raw[47:0];
        end
    end

    // weight step: rate * x, sign of label, rounded to q16.16
    assign w_rx = $signed({1'b0, r_rate}) * w_rd_s;
    assign w_d  = r_pos ? (34'(w_rx) + 34'sd128) : (-34'(w_rx) + 34'sd128);

    assign w_wsum = 34'(w_rd_w) + 34'(r_step);
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_wdata = '0;
        end else if (w_wsum > W_MAX) begin
            w_wdata = 32'(W_MAX);
        end else if (w_wsum < W_MIN) begin
            w_wdata = 32'(W_MIN);
        end else begin
            w_wdata = w_wsum[31:0];
        end
    end

    assign w_mag     = w_rd_w[31] ? (32'd0 - w_rd_w) : w_rd_w;
    assign w_acc_sum = {1'b0, r_sum} + {1'b0, r_sq};
    assign w_bstep   = $signed({5'b00000, r_rate}) <<< 4;
    assign w_bsum    = r_pos ? (34'(r_bias) + 34'(w_bstep)) : (34'(r_bias) - 34'(w_bstep));

    // saturating counters after this sample
    always_comb begin
        n_upd  = r_upd;
        n_mcnt = r_mcnt;
        if (r_miss && r_upd != 32'hFFFF_FFFF) begin
            n_upd = r_upd + 32'd1;
        end
        if (r_miss && r_mcnt != 16'hFFFF) begin
            n_mcnt = r_mcnt + 16'd1;
        end
    end

    // memory port control
    assign w_we = (r_state == S_CLEAR) || (r_state == S_UPD_WR);
    assign w_re = (w_accept && w_fits) || (r_state == S_UPD_RD) || (r_state == S_NRM_RD);
    assign w_raddr = (r_state == S_IDLE) ? r_cnt[AW-1:0] : r_idx[AW-1:0];
    assign w_sqrt_start = (r_state == S_NRM_ADD) && (r_idx == CW'(DIM_MAX - 1));

    pts_store #(.DIM_MAX(DIM_MAX), .AW(AW)) u_store (
        .i_clk     (i_clk),
        .i_w_we    (w_we),
        .i_w_waddr (r_idx[AW-1:0]),
        .i_w_wdata (w_wdata),
        .i_s_we    (w_accept && w_fits),
        .i_s_waddr (r_cnt[AW-1:0]),
        .i_s_wdata (i_feature),
        .i_re      (w_re),
        .i_raddr   (w_raddr),
        .o_w_rdata (w_rd_w),
        .o_s_rdata (w_rd_s)
    );

    pts_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (w_acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : w_acc_sum[63:0]),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_rate  <= RATE_RESET;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_pend  <= 1'b0;
            r_acc   <= '0;
            r_bias  <= '0;
            r_norm  <= '0;
            r_upd   <= '0;
            r_mcnt  <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_rate <= i_cfg_wr_data;
            end
            // a result taken here is refilled by the done state itself
            if (o_valid && !i_stall && r_state != S_DONE) begin
                o_valid <= 1'b0;
            end
            // the previous product folds in while the next request is read
            if (r_pend) begin
                r_acc  <= r_acc + 64'(r_prod);
                r_pend <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + CW'(1);
                    if (r_idx == CW'(DIM_MAX - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_new_pass) begin
                            r_mcnt <= '0;
                        end
                        if (w_fits) begin
                            r_cnt <= r_cnt + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        r_have  <= w_fits;
                        r_x     <= i_feature;
                        r_last  <= i_last_feature;
                        r_pos   <= i_label_positive;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_have ? 48'(w_rd_w * r_x) : '0;
                    r_pend  <= 1'b1;
                    r_state <= r_last ? S_ACC : S_IDLE;
                end
                S_ACC: begin
                    r_state <= S_SCORE;
                end
                S_SCORE: begin
                    r_score <= w_sc;
                    r_miss  <= r_pos ? (w_sc <= 48'sd0) : (w_sc >= 48'sd0);
                    r_idx   <= '0;
                    r_sum   <= '0;
                    r_state <= (r_pos ? (w_sc <= 48'sd0) : (w_sc >= 48'sd0))
                               ? S_UPD_RD : S_DONE;
                end
                S_UPD_RD: begin
                    r_state <= S_UPD_MUL;
                end
                S_UPD_MUL: begin
                    r_step  <= 26'(w_d >>> 8);
                    r_state <= S_UPD_WR;
                end
                S_UPD_WR: begin
                    if (r_idx + CW'(1) == r_cnt) begin
                        r_idx   <= '0;
                        r_state <= S_NRM_RD;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_UPD_RD;
                    end
                end
                S_NRM_RD: begin
                    r_state <= S_NRM_SQ;
                end
                S_NRM_SQ: begin
                    r_sq    <= w_mag * w_mag;
                    r_state <= S_NRM_ADD;
                end
                S_NRM_ADD: begin
                    // saturating sum of squares
                    r_sum <= w_acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : w_acc_sum[63:0];
                    if (r_idx == CW'(DIM_MAX - 1)) begin
                        r_state <= S_SQRT;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_NRM_RD;
                    end
                end
                S_SQRT: begin
                    if (w_sqrt_done) begin
                        r_norm  <= w_root;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        o_valid             <= 1'b1;
                        o_mistake           <= r_miss;
                        o_score             <= r_score;
                        o_weight_norm       <= r_norm;
                        o_too_many_features <= r_ovf;
                        o_pass_mistakes     <= n_mcnt;
                        o_total_updates     <= n_upd;
                        r_mcnt              <= n_mcnt;
                        r_upd               <= n_upd;
                        if (r_miss) begin
                            if (w_bsum > W_MAX) begin
                                r_bias <= 32'(W_MAX);
                            end else if (w_bsum < W_MIN) begin
                                r_bias <= 32'(W_MIN);
                            end else begin
                                r_bias <= w_bsum[31:0];
                            end
                        end
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### tb/tb_perceptron_train_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_perceptron_train_step
// self-checking bench for the fixed-point perceptron training step
// ----------------------------------------------------------------------------
// feature requests come from a queue that the stimulus process fills
// - a short directed set, then random samples over several learning rates.
// A built-in model of the learner predicts one result per sample when the
// last feature is accepted. The monitor compares each result with the
// oldest prediction. Both channels idle at random. The receiver also holds
// off once for a long stretch, so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_perceptron_train_step;
    import pts_pkg::*;

    localparam int DIM       = 64;
    localparam int SETTLE    = 600;     // settling wait, longer than the worst mistake update
    localparam int WD_LIMIT  = 20000;   // well above the long hold-off of HOLD_LEN
    localparam int HOLD_LEN  = 2000;

    typedef struct packed {
        logic signed [15:0] feature;
        logic               label_pos;
        logic               last;
        logic               new_pass;
    } feat_req_t;

    typedef struct packed {
        logic               mistake;
        logic signed [47:0] score;
        logic [31:0]        norm;
        logic [15:0]        pass_mistakes;
        logic [31:0]        total_updates;
        logic               too_many;
    } sample_res_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [15:0] i_feature = '0;
    logic i_label_positive = 1'b0;
    logic i_last_feature = 1'b0;
    logic i_new_pass = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_mistake;
    logic signed [47:0] o_score;
    logic [31:0] o_weight_norm;
    logic [15:0] o_pass_mistakes;
    logic [31:0] o_total_updates;
    logic o_too_many_features;

    perceptron_train_step #(.DIM_MAX(DIM)) i_dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // learner model: weights, bias, running sample and counters
    // ------------------------------------------------------------------
    logic [15:0]        rate_q412 = RATE_RESET;
    t_weight            w_mem [DIM];
    t_feature           x_buf [DIM];
    t_weight            bias_q = '0;
    logic signed [63:0] dot_acc = '0;
    int unsigned        n_feat = 0;
    logic [31:0]        norm_q = '0;
    logic [15:0]        miss_cnt = '0;
    logic [31:0]        upd_cnt = '0;
    logic               extra_seen = 1'b0;

    feat_req_t   pending_reqs [$];
    sample_res_t expected_results [$];

    int unsigned mismatches = 0;
    int unsigned reqs_taken = 0;
    bit          calm = 1'b0;       // no idling on either side

    initial for (int k = 0; k < DIM; k++) w_mem[k] = '0;

    function automatic t_weight sat_w(longint v);
        if (v > longint'(W_MAX)) return t_weight'(W_MAX);
        if (v < longint'(W_MIN)) return t_weight'(W_MIN);
        return t_weight'(v);
    endfunction

    function automatic logic [31:0] int_sqrt(logic [63:0] n);
        logic [63:0] r, b;
        r = '0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    // one accepted feature request; returns 1 with a result on the last one
    function automatic bit learn_step(feat_req_t q, output sample_res_t res);
        longint sc, d, bstep;
        logic [64:0] sq_sum;
        logic [63:0] mag;
        bit miss;
        if (q.new_pass) miss_cnt = '0;
        if (n_feat < DIM) begin
            x_buf[n_feat] = q.feature;
            dot_acc = dot_acc + longint'(w_mem[n_feat]) * longint'(q.feature);
            n_feat++;
        end else begin
            extra_seen = 1'b1;
        end
        if (!q.last) return 1'b0;

        // arithmetic shift floors, so no rounding fix-up is needed
        sc = (dot_acc >>> 12) + longint'(bias_q);
        if (sc > longint'(SCORE_MAX)) sc = longint'(SCORE_MAX);
        if (sc < longint'(SCORE_MIN)) sc = longint'(SCORE_MIN);
        miss = q.label_pos ? (sc <= 0) : (sc >= 0);

        if (miss) begin
            for (int k = 0; k < n_feat; k++) begin
                d = longint'(rate_q412) * longint'(x_buf[k]);
                if (!q.label_pos) d = -d;
                d = (d + 128) >>> 8;
                w_mem[k] = sat_w(longint'(w_mem[k]) + d);
            end
            sq_sum = '0;
            for (int k = 0; k < DIM; k++) begin
                mag = (w_mem[k] < 0) ? 64'(-longint'(w_mem[k])) : 64'(w_mem[k]);
                sq_sum = sq_sum + mag * mag;
                if (sq_sum[64]) sq_sum = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
            end
            norm_q = int_sqrt(sq_sum[63:0]);
            bstep = longint'(rate_q412) * 16;
            bias_q = sat_w(longint'(bias_q) + (q.label_pos ? bstep : -bstep));
            if (upd_cnt != 32'hFFFF_FFFF) upd_cnt++;
            if (miss_cnt != 16'hFFFF) miss_cnt++;
        end

        res.mistake       = miss;
        res.score         = sc[47:0];
        res.norm          = norm_q;
        res.pass_mistakes = miss_cnt;
        res.total_updates = upd_cnt;
        res.too_many      = extra_seen;
        dot_acc = '0;
        n_feat = 0;
        extra_seen = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // request driver: predicts on acceptance, then offers the next request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        sample_res_t r;
        feat_req_t q;
        if (i_rst_n && !(i_valid && o_stall)) begin
            if (i_valid) begin
                if (learn_step({i_feature, i_label_positive, i_last_feature, i_new_pass}, r))
                    expected_results.push_back(r);
                reqs_taken++;
            end
            if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
                q = pending_reqs.pop_front();
                i_valid          <= 1'b1;
                i_feature        <= q.feature;
                i_label_positive <= q.label_pos;
                i_last_feature   <= q.last;
                i_new_pass       <= q.new_pass;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver stall: random, plus one long hold-off partway through
    // ------------------------------------------------------------------
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!hold_done && reqs_taken >= 300) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < 32);
        end
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        sample_res_t got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_mistake, o_score, o_weight_norm, o_pass_mistakes,
                   o_total_updates, o_too_many_features};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", got);
            end else begin
                want = expected_results.pop_front();
                if (got.mistake !== want.mistake || got.score !== want.score ||
                    got.norm !== want.norm || got.pass_mistakes !== want.pass_mistakes ||
                    got.total_updates !== want.total_updates ||
                    got.too_many !== want.too_many) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result differs: expected %p actual %p", want, got);
                end
            end
        end
    end

    // watchdog: cycles with no request or result accepted
    int unsigned quiet = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WD_LIMIT) begin
            $display("perceptron_train_step: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic logic signed [15:0] pick_feature();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3, 4:    return $signed(16'($urandom_range(8191))) - 16'sd4096;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic queue_sample(int len, bit pos, bit np);
        feat_req_t q;
        for (int k = 0; k < len; k++) begin
            q.feature   = pick_feature();
            q.label_pos = (k == len - 1) ? pos : 1'($urandom());
            q.last      = (k == len - 1);
            // a new pass mark may turn up on any request
            q.new_pass  = (k == 0) ? np : ($urandom_range(19) == 0);
            pending_reqs.push_back(q);
        end
    endtask

    task automatic queue_random(int n_reqs);
        int len, queued;
        queued = 0;
        while (queued < n_reqs) begin
            case ($urandom_range(19))
                0:       len = DIM;
                1:       len = DIM + 1 + $urandom_range(5);
                2, 3, 4: len = 9 + $urandom_range(DIM - 10);
                default: len = 1 + $urandom_range(7);
            endcase
            queue_sample(len, 1'($urandom()), $urandom_range(7) == 0);
            queued += len;
        end
    endtask

    task automatic settle();
        wait (pending_reqs.size() == 0 && expected_results.size() == 0 && !i_valid);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_rate(logic [15:0] v);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        rate_q412      = v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, both labels, new pass mid sample, short samples
        pending_reqs.push_back({16'sh7FFF, 1'b1, 1'b1, 1'b1});   // zero score, positive
        pending_reqs.push_back({16'sh8000, 1'b0, 1'b1, 1'b0});   // negative score, negative label
        pending_reqs.push_back({16'sh7FFF, 1'b1, 1'b1, 1'b0});
        pending_reqs.push_back({16'sh0000, 1'b0, 1'b1, 1'b0});
        pending_reqs.push_back({16'sh8000, 1'b1, 1'b0, 1'b0});
        pending_reqs.push_back({16'sh7FFF, 1'b0, 1'b0, 1'b1});   // clear inside a sample
        pending_reqs.push_back({16'sh5555, 1'b1, 1'b1, 1'b0});
        pending_reqs.push_back({16'shAAAA, 1'b0, 1'b1, 1'b1});
        pending_reqs.push_back({16'sh0001, 1'b1, 1'b0, 1'b0});
        pending_reqs.push_back({16'shFFFF, 1'b0, 1'b0, 1'b0});
        pending_reqs.push_back({16'sh1000, 1'b0, 1'b1, 1'b0});
        settle();

        write_rate(16'd0);              // no step at all
        queue_random(150);
        settle();

        write_rate(16'hFFFF);           // largest step, drives weights to saturation
        queue_random(300);
        settle();

        write_rate(16'd1);
        queue_random(250);
        settle();

        write_rate(16'($urandom()));
        calm = 1'b1;
        queue_random(250);
        settle();
        calm = 1'b0;

        write_rate(RATE_RESET);
        queue_random(450);
        settle();

        if (mismatches == 0)
            $display("perceptron_train_step: match");
        else
            $display("perceptron_train_step: mismatch");
        $finish;
    end

endmodule

### filelist.f
src/pts_pkg.sv
src/pts_store.sv
src/pts_isqrt.sv
src/perceptron_train_step.sv
tb/tb_perceptron_train_step.sv
